/* design/nprs_pkg.sv */
// Package for the network profile rotation selector.
// Holds the payload structs, configuration register codes and widths.
// No dependencies; the top level refers to it by scoped names.
package nprs_pkg;

	// Field widths, fixed by the request and result formats.
	localparam int TIME_W = 32;
	localparam int MASK_W = 4;
	localparam int INDEX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Default number of profile slots.
	localparam int PROFILE_SLOTS = 4;

	// Attempt window after reset, in milliseconds.
	localparam logic [TIME_W-1:0] ATTEMPT_WINDOW_RESET = 32'd10000;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_PRESENT_MASK   = 1'b0,
		CFG_ATTEMPT_WINDOW = 1'b1
	} cfg_reg_t;

	// One input request: link state and current time.
	typedef struct packed {
		logic              link_up;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	// One result: whether to connect, and to which slot.
	typedef struct packed {
		logic               select_valid;
		logic [INDEX_W-1:0] profile_index;
	} rsp_t;

endpackage

/* design/nprs_rr_pick.sv */
// Round-robin slot picker for the network profile rotation selector.
// Finds the first present slot at or after a start slot, wrapping around.
// Depends on nothing but its parameters.
module nprs_rr_pick #(
	parameter int SLOTS  = 4,
	parameter int SLOT_W = 2
) (
	input  logic [SLOTS-1:0]  present,
	input  logic [SLOT_W-1:0] start,
	output logic              found,
	output logic [SLOT_W-1:0] slot
);

	localparam int SUM_W = SLOT_W + 1;

	logic [SUM_W-1:0] cand;

	// Walk the offsets from the farthest down, so the nearest present slot wins.
	always_comb begin
		found = 1'b0;
		slot = '0;
		cand = '0;
		for (int off = SLOTS - 1; off >= 0; off--) begin
			cand = {1'b0, start} + SUM_W'(off);
			if (cand >= SUM_W'(SLOTS)) begin
				cand = cand - SUM_W'(SLOTS);
			end
			if (present[cand[SLOT_W-1:0]]) begin
				found = 1'b1;
				slot = cand[SLOT_W-1:0];
			end
		end
	end

endmodule

/* design/network_profile_rotation_selector_core.sv */
// Top level of the network profile rotation selector.
// Uses nprs_pkg for types and constants and nprs_rr_pick for the slot scan.
//
//  Channel | Signals                         | Direction | Transfers when
//  --------+---------------------------------+-----------+---------------------------
//  request | req_valid, req_stall, req_data  | in        | req_valid && !req_stall
//  result  | rsp_valid, rsp_stall, rsp_data  | out       | rsp_valid && !rsp_stall
//  config  | cfg_valid, cfg_ready, cfg_index,| in        | cfg_valid && cfg_ready
//          | cfg_data                        |           |
//
// Each request gives exactly one result. A request is captured in an input
// register, decided by the logic behind it, and its result lands in the
// output register when the input register advances, which a stalled result
// can hold off. One request per cycle is sustained while results are not
// stalled, as the state updates with each decision. A stalled result holds
// the pipeline; req_stall rises only when both registers are full. Reset
// clears selector state, mask and both valid flags and presets the window.
module network_profile_rotation_selector_core #(
	parameter int PROFILE_SLOTS = nprs_pkg::PROFILE_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request channel.
	input  logic                              req_valid,
	output logic                              req_stall,
	input  nprs_pkg::req_t                    req_data,
	// Result channel.
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output nprs_pkg::rsp_t                    rsp_data,
	// Configuration channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  nprs_pkg::cfg_reg_t                cfg_index,
	input  logic [nprs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SLOT_W = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
	localparam int TIME_W = nprs_pkg::TIME_W;
	localparam int MASK_W = nprs_pkg::MASK_W;
	localparam int INDEX_W = nprs_pkg::INDEX_W;

	// Configuration registers.
	logic [MASK_W-1:0] present_mask_q;
	logic [TIME_W-1:0] attempt_window_q;

	// Selector state.
	logic              was_connected_q;
	logic              have_current_q;
	logic [SLOT_W-1:0] current_slot_q;
	logic [TIME_W-1:0] attempt_start_q;

	// Pipeline registers.
	logic              req_valid_s1;
	nprs_pkg::req_t    req_s1;
	logic              rsp_valid_q;
	nprs_pkg::rsp_t    rsp_q;

	// Decision logic signals.
	logic              out_load;
	logic              advance;
	logic [PROFILE_SLOTS-1:0] present;
	logic [SLOT_W-1:0] scan_start;
	logic              pick_found;
	logic [SLOT_W-1:0] pick_slot;
	logic [TIME_W-1:0] elapsed;
	logic              window_open;
	logic              was_connected_d;
	logic              have_current_d;
	logic [SLOT_W-1:0] current_slot_d;
	logic [TIME_W-1:0] attempt_start_d;
	logic              sel_d;
	logic [SLOT_W-1:0] sel_slot_d;
	logic [SLOT_W+INDEX_W-1:0] sel_slot_ext;
	nprs_pkg::rsp_t    rsp_d;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_mask_q <= '0;
			attempt_window_q <= nprs_pkg::ATTEMPT_WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				nprs_pkg::CFG_PRESENT_MASK: present_mask_q <= cfg_data[MASK_W-1:0];
				nprs_pkg::CFG_ATTEMPT_WINDOW: attempt_window_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the output register loads when empty or drained, and the
	// input register moves on whenever its content goes to the output.
	assign out_load = !rsp_valid_q || !rsp_stall;
	assign advance = req_valid_s1 && out_load;
	assign req_stall = req_valid_s1 && !out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
	end

	// Slots beyond the mask register never hold a profile.
	for (genvar i = 0; i < PROFILE_SLOTS; i++) begin : g_present
		if (i < MASK_W) begin : g_mask
			assign present[i] = present_mask_q[i];
		end else begin : g_absent
			assign present[i] = 1'b0;
		end
	end

	// The scan starts after the held slot, or at slot zero with none held.
	always_comb begin
		scan_start = '0;
		if (have_current_q && current_slot_q != SLOT_W'(PROFILE_SLOTS - 1)) begin
			scan_start = current_slot_q + SLOT_W'(1);
		end
	end

	nprs_rr_pick #(
		.SLOTS  (PROFILE_SLOTS),
		.SLOT_W (SLOT_W)
	) u_pick (
		.present (present),
		.start   (scan_start),
		.found   (pick_found),
		.slot    (pick_slot)
	);

	// Time since the attempt began wraps modulo 2^32.
	assign elapsed = req_s1.now_ms - attempt_start_q;
	assign window_open = elapsed < attempt_window_q;

	// Decide the result and the next state for the request in the input register.
	always_comb begin
		was_connected_d = was_connected_q;
		have_current_d = have_current_q;
		current_slot_d = current_slot_q;
		attempt_start_d = attempt_start_q;
		sel_d = 1'b0;
		sel_slot_d = '0;
		if (req_s1.link_up) begin
			was_connected_d = 1'b1;
		end else if (was_connected_q) begin
			// Link just lost: retry the held slot once and restart the timer.
			was_connected_d = 1'b0;
			attempt_start_d = req_s1.now_ms;
			if (have_current_q) begin
				sel_d = 1'b1;
				sel_slot_d = current_slot_q;
			end
		end else if (!(have_current_q && window_open) && pick_found) begin
			// Window over or nothing held: rotate to the next present slot.
			have_current_d = 1'b1;
			current_slot_d = pick_slot;
			attempt_start_d = req_s1.now_ms;
			sel_d = 1'b1;
			sel_slot_d = pick_slot;
		end
	end

	// The result carries the low bits of the slot number.
	assign sel_slot_ext = {{INDEX_W{1'b0}}, sel_slot_d};
	assign rsp_d.select_valid = sel_d;
	assign rsp_d.profile_index = sel_slot_ext[INDEX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_connected_q <= 1'b0;
			have_current_q <= 1'b0;
			current_slot_q <= '0;
			attempt_start_q <= '0;
		end else if (advance) begin
			was_connected_q <= was_connected_d;
			have_current_q <= have_current_d;
			current_slot_q <= current_slot_d;
			attempt_start_q <= attempt_start_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

endmodule
